@@ hdl/tlvmp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlvmp_pkg
// Shared types and constants of the type-length-value message parser.
// ----------------------------------------------------------------------------
package tlvmp_pkg;

  localparam int MAX_FIELD_IDS  = 16;
  localparam int HDR_BYTES      = 6;
  localparam int MASK_IDS       = 16;
  localparam int RES_FIFO_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [1:0] REG_EXPECTED_TYPE    = 2'd0;
  localparam logic [1:0] REG_FIELD_VALID_MASK = 2'd1;
  localparam logic [1:0] REG_FIELD_TYPE_CODES = 2'd2;

  // Field type codes.
  localparam logic [2:0] CODE_INT32   = 3'd0;
  localparam logic [2:0] CODE_UINT32  = 3'd1;
  localparam logic [2:0] CODE_INT64   = 3'd2;
  localparam logic [2:0] CODE_UINT64  = 3'd3;
  localparam logic [2:0] CODE_STR     = 3'd4;
  localparam logic [2:0] CODE_BUF     = 3'd5;
  localparam logic [2:0] CODE_ARRAY   = 3'd6;
  localparam logic [2:0] CODE_MESSAGE = 3'd7;

  typedef enum logic [2:0] {
    PH_MSG_HDR,
    PH_FLD_HDR,
    PH_FLD_BODY,
    PH_DONE,
    PH_BAD_TYPE,
    PH_OVERRUN
  } phase_e;

  typedef enum logic [1:0] {
    KIND_INT,
    KIND_BUF_START,
    KIND_PAYLOAD,
    KIND_STATUS
  } res_kind_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SHORT,
    ST_WRONG_TYPE,
    ST_OVERRUN
  } status_e;

  typedef struct packed {
    logic [15:0] expected_type;
    logic [15:0] field_valid_mask;
    logic [47:0] field_type_codes;
  } cfg_t;

  typedef struct packed {
    res_kind_e   kind;
    logic [3:0]  field_id;
    logic [2:0]  field_kind;
    logic [63:0] int_value;
    logic [23:0] field_length;
    logic [7:0]  payload_byte;
    logic        last_of_field;
    status_e     status;
    logic [15:0] set_mask;
    logic        last_result;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/tlvmp_intf.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlvmp interfaces
// Byte input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface tlvmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, data_byte, end_of_buffer, input ready);
  modport sink   (input valid, data_byte, end_of_buffer, output ready);
endinterface

interface tlvmp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  field_id;
  logic [2:0]  field_kind;
  logic [63:0] int_value;
  logic [23:0] field_length;
  logic [7:0]  payload_byte;
  logic        last_of_field;
  logic [1:0]  status;
  logic [15:0] set_mask;
  logic        last_result;

  modport source (output valid, kind, field_id, field_kind, int_value, field_length,
                  payload_byte, last_of_field, status, set_mask, last_result,
                  input ready);
  modport sink   (input valid, kind, field_id, field_kind, int_value, field_length,
                  payload_byte, last_of_field, status, set_mask, last_result,
                  output ready);
endinterface

interface tlvmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/tlv_message_parser_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlv_message_parser_core
// Type-length-value message deframer, one wire byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while input ready is high. Each
// byte is parsed in the cycle of its transfer and its results (none, one,
// or a field result followed by the message status) enter a four-entry
// registered result queue that offers them in order. The output gives one
// result per cycle while output ready is high, so the sustained rate is
// one byte per cycle as long as bytes bring at most one result on average;
// input ready drops while the queue has fewer than two free entries. No
// clearing pass is needed after reset. Configuration writes are taken at any
// time with ready held high and must only be made while the block is idle.
module tlv_message_parser_core #(
  parameter int MaxFieldIds = tlvmp_pkg::MAX_FIELD_IDS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  tlvmp_in_if.sink      in_i,
  tlvmp_out_if.source   out_o,
  tlvmp_cfg_if.sink     cfg_i
);

  tlvmp_pkg::cfg_t    cfg;
  tlvmp_pkg::result_t res0, res1, head;
  logic [1:0]         res_cnt;
  logic               room, take, q_valid;

  assign in_i.ready = room;
  assign take       = in_i.valid && room;

  tlvmp_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_i),
    .cfg_o  (cfg)
  );

  tlvmp_parser #(
    .MaxFieldIds (MaxFieldIds)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .take_i      (take),
    .data_byte_i (in_i.data_byte),
    .eob_i       (in_i.end_of_buffer),
    .res_cnt_o   (res_cnt),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  tlvmp_result_fifo u_result_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (take ? res_cnt : 2'd0),
    .push0_i    (res0),
    .push1_i    (res1),
    .room_o     (room),
    .valid_o    (q_valid),
    .pop_i      (out_o.ready),
    .head_o     (head)
  );

  assign out_o.valid         = q_valid;
  assign out_o.kind          = head.kind;
  assign out_o.field_id      = head.field_id;
  assign out_o.field_kind    = head.field_kind;
  assign out_o.int_value     = head.int_value;
  assign out_o.field_length  = head.field_length;
  assign out_o.payload_byte  = head.payload_byte;
  assign out_o.last_of_field = head.last_of_field;
  assign out_o.status        = head.status;
  assign out_o.set_mask      = head.set_mask;
  assign out_o.last_result   = head.last_result;

endmodule
`default_nettype wire

@@ hdl/tlvmp_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlvmp_cfg_regs
// Configuration registers: expected message type, valid ids, type codes.
// ----------------------------------------------------------------------------
module tlvmp_cfg_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tlvmp_cfg_if.sink        cfg,
  output tlvmp_pkg::cfg_t  cfg_o
);

  tlvmp_pkg::cfg_t cfg_q;

  assign cfg.ready = 1'b1;
  assign cfg_o     = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        tlvmp_pkg::REG_EXPECTED_TYPE:    cfg_q.expected_type    <= cfg.data[15:0];
        tlvmp_pkg::REG_FIELD_VALID_MASK: cfg_q.field_valid_mask <= cfg.data[15:0];
        tlvmp_pkg::REG_FIELD_TYPE_CODES: cfg_q.field_type_codes <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/tlvmp_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlvmp_parser
// Per-byte parse state and generation of up to two results per byte.
// ----------------------------------------------------------------------------
module tlvmp_parser #(
  parameter int MaxFieldIds = tlvmp_pkg::MAX_FIELD_IDS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  tlvmp_pkg::cfg_t        cfg_i,
  input  wire logic              take_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              eob_i,
  output logic [1:0]             res_cnt_o,
  output tlvmp_pkg::result_t     res0_o,
  output tlvmp_pkg::result_t     res1_o
);

  localparam int IdLimit =
    (MaxFieldIds < tlvmp_pkg::MASK_IDS) ? MaxFieldIds : tlvmp_pkg::MASK_IDS;

  tlvmp_pkg::phase_e phase_q, phase_d;
  logic [31:0] offs_q, offs_d, offs_n;
  logic [31:0] body_len_q, body_len_d;
  logic [32:0] body_end_q, body_end_d;
  logic [15:0] hdr_shift_q, hdr_shift_d;
  logic [2:0]  sub_cnt_q, sub_cnt_d;
  logic [15:0] cur_id_q, cur_id_d;
  logic [7:0]  cur_wt_q, cur_wt_d;
  logic [23:0] cur_len_q, cur_len_d;
  logic [23:0] pay_cnt_q, pay_cnt_d;
  logic [63:0] acc_q, acc_d;
  logic        fld_acc_q, fld_acc_d;
  logic [15:0] rmask_q, rmask_d;

  logic        at_end;
  logic [32:0] remaining;
  logic [3:0]  idx;
  logic [2:0]  code;
  logic [3:0]  int_w;
  logic [23:0] pc_inc;
  logic        accept;
  logic        fres_v;
  tlvmp_pkg::result_t fres, sres;

  always_comb begin
    phase_d     = phase_q;
    offs_d      = offs_q;
    body_len_d  = body_len_q;
    hdr_shift_d = hdr_shift_q;
    sub_cnt_d   = sub_cnt_q;
    cur_id_d    = cur_id_q;
    cur_wt_d    = cur_wt_q;
    cur_len_d   = cur_len_q;
    pay_cnt_d   = pay_cnt_q;
    acc_d       = acc_q;
    fld_acc_d   = fld_acc_q;
    rmask_d     = rmask_q;
    fres_v      = 1'b0;
    fres        = '0;
    sres        = '0;
    accept      = 1'b0;
    idx         = 4'd0;
    code        = 3'd0;
    int_w       = 4'd4;
    pc_inc      = pay_cnt_q + 24'd1;
    remaining   = '0;

    // The offset saturates so that a body that cannot complete ends as short.
    offs_n = (offs_q == 32'hFFFF_FFFF) ? offs_q : offs_q + 32'd1;
    offs_d = offs_n;
    at_end = {1'b0, offs_n} >= body_end_q;

    case (phase_q)
      tlvmp_pkg::PH_MSG_HDR: begin
        if (sub_cnt_q < 3'd4) begin
          body_len_d = {body_len_q[23:0], data_byte_i};
        end else begin
          hdr_shift_d = {hdr_shift_q[7:0], data_byte_i};
        end
        if (sub_cnt_q == 3'(tlvmp_pkg::HDR_BYTES - 1)) begin
          sub_cnt_d = 3'd0;
          if (hdr_shift_d != cfg_i.expected_type) begin
            phase_d = tlvmp_pkg::PH_BAD_TYPE;
          end else if (at_end) begin
            phase_d = tlvmp_pkg::PH_DONE;
          end else begin
            phase_d = tlvmp_pkg::PH_FLD_HDR;
          end
        end else begin
          sub_cnt_d = sub_cnt_q + 3'd1;
        end
      end

      tlvmp_pkg::PH_FLD_HDR: begin
        if (sub_cnt_q == 3'd0) begin
          cur_id_d  = '0;
          cur_len_d = '0;
        end
        if (sub_cnt_q < 3'd2) begin
          cur_id_d = {cur_id_d[7:0], data_byte_i};
        end else if (sub_cnt_q == 3'd2) begin
          cur_wt_d = data_byte_i;
        end else begin
          cur_len_d = {cur_len_d[15:0], data_byte_i};
        end
        if (sub_cnt_q != 3'(tlvmp_pkg::HDR_BYTES - 1)) begin
          sub_cnt_d = sub_cnt_q + 3'd1;
          if (at_end) phase_d = tlvmp_pkg::PH_OVERRUN;
        end else begin
          sub_cnt_d = 3'd0;
          pay_cnt_d = '0;
          acc_d     = '0;
          fld_acc_d = 1'b0;
          remaining = body_end_q - {1'b0, offs_n};
          if ({9'd0, cur_len_d} > remaining) begin
            phase_d = tlvmp_pkg::PH_OVERRUN;
          end else begin
            idx    = cur_id_d[3:0];
            code   = cfg_i.field_type_codes[idx*3 +: 3];
            int_w  = (code < tlvmp_pkg::CODE_INT64) ? 4'd4 : 4'd8;
            accept = (cur_id_d < 16'(IdLimit)) && cfg_i.field_valid_mask[idx] &&
                     (cur_wt_d == {5'd0, code});
            // An integer field shorter than its width is ignored.
            if (code <= tlvmp_pkg::CODE_UINT64 && cur_len_d < {20'd0, int_w}) begin
              accept = 1'b0;
            end
            if (accept && code >= tlvmp_pkg::CODE_STR) begin
              rmask_d = rmask_d | (16'd1 << idx);
              if (code <= tlvmp_pkg::CODE_BUF) begin
                fres_v            = 1'b1;
                fres.kind         = tlvmp_pkg::KIND_BUF_START;
                fres.field_length = cur_len_d;
              end
            end
            fld_acc_d = accept;
            if (cur_len_d == 24'd0) begin
              phase_d = at_end ? tlvmp_pkg::PH_DONE : tlvmp_pkg::PH_FLD_HDR;
            end else begin
              phase_d = tlvmp_pkg::PH_FLD_BODY;
            end
          end
        end
      end

      tlvmp_pkg::PH_FLD_BODY: begin
        code  = cur_wt_q[2:0];
        int_w = (code < tlvmp_pkg::CODE_INT64) ? 4'd4 : 4'd8;
        if (fld_acc_q) begin
          if (code <= tlvmp_pkg::CODE_UINT64) begin
            if (pay_cnt_q < {20'd0, int_w}) begin
              acc_d = {acc_q[55:0], data_byte_i};
              if (pc_inc == {20'd0, int_w}) begin
                rmask_d        = rmask_d | (16'd1 << cur_id_q[3:0]);
                fres_v         = 1'b1;
                fres.kind      = tlvmp_pkg::KIND_INT;
                fres.int_value = acc_d;
              end
            end
          end else if (code <= tlvmp_pkg::CODE_BUF) begin
            fres_v             = 1'b1;
            fres.kind          = tlvmp_pkg::KIND_PAYLOAD;
            fres.payload_byte  = data_byte_i;
            fres.last_of_field = (pc_inc == cur_len_q);
          end
        end
        pay_cnt_d = pc_inc;
        if (pc_inc >= cur_len_q) begin
          sub_cnt_d = 3'd0;
          phase_d   = at_end ? tlvmp_pkg::PH_DONE : tlvmp_pkg::PH_FLD_HDR;
        end
      end

      default: ;
    endcase

    fres.field_id   = cur_id_d[3:0];
    fres.field_kind = cur_wt_d[2:0];

    sres.kind     = tlvmp_pkg::KIND_STATUS;
    sres.set_mask = rmask_d;
    if (phase_d == tlvmp_pkg::PH_MSG_HDR || !at_end) begin
      sres.status = tlvmp_pkg::ST_SHORT;
    end else if (phase_d == tlvmp_pkg::PH_BAD_TYPE) begin
      sres.status = tlvmp_pkg::ST_WRONG_TYPE;
    end else if (phase_d == tlvmp_pkg::PH_OVERRUN) begin
      sres.status = tlvmp_pkg::ST_OVERRUN;
    end else begin
      sres.status = tlvmp_pkg::ST_OK;
    end

    // The last byte of a buffer restarts parsing from a clean state.
    if (eob_i) begin
      phase_d     = tlvmp_pkg::PH_MSG_HDR;
      offs_d      = '0;
      body_len_d  = '0;
      hdr_shift_d = '0;
      sub_cnt_d   = '0;
      cur_id_d    = '0;
      cur_wt_d    = '0;
      cur_len_d   = '0;
      pay_cnt_d   = '0;
      acc_d       = '0;
      fld_acc_d   = 1'b0;
      rmask_d     = '0;
    end
    body_end_d = {1'b0, body_len_d} + 33'(tlvmp_pkg::HDR_BYTES);
  end

  always_comb begin
    res0_o = fres_v ? fres : sres;
    res1_o = sres;
    res_cnt_o = {1'b0, fres_v} + {1'b0, eob_i};
    res0_o.last_result = !(fres_v && eob_i);
    res1_o.last_result = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tlvmp_pkg::PH_MSG_HDR;
      offs_q      <= '0;
      body_len_q  <= '0;
      body_end_q  <= 33'(tlvmp_pkg::HDR_BYTES);
      hdr_shift_q <= '0;
      sub_cnt_q   <= '0;
      cur_id_q    <= '0;
      cur_wt_q    <= '0;
      cur_len_q   <= '0;
      pay_cnt_q   <= '0;
      acc_q       <= '0;
      fld_acc_q   <= 1'b0;
      rmask_q     <= '0;
    end else if (take_i) begin
      phase_q     <= phase_d;
      offs_q      <= offs_d;
      body_len_q  <= body_len_d;
      body_end_q  <= body_end_d;
      hdr_shift_q <= hdr_shift_d;
      sub_cnt_q   <= sub_cnt_d;
      cur_id_q    <= cur_id_d;
      cur_wt_q    <= cur_wt_d;
      cur_len_q   <= cur_len_d;
      pay_cnt_q   <= pay_cnt_d;
      acc_q       <= acc_d;
      fld_acc_q   <= fld_acc_d;
      rmask_q     <= rmask_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/tlvmp_result_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlvmp_result_fifo
// Result queue: takes up to two results per cycle, gives one per cycle when popped.
// ----------------------------------------------------------------------------
module tlvmp_result_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [1:0]    push_cnt_i,
  input  tlvmp_pkg::result_t push0_i,
  input  tlvmp_pkg::result_t push1_i,
  output logic               room_o,
  output logic               valid_o,
  input  wire logic          pop_i,
  output tlvmp_pkg::result_t head_o
);

  localparam int Depth = tlvmp_pkg::RES_FIFO_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  tlvmp_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  // Room for a worst-case byte, which brings two results.
  assign room_o  = cnt_q <= CntW'(Depth - 2);
  assign valid_o = cnt_q != '0;
  assign pop     = pop_i && valid_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_cnt_i == 2'd2) mem_q[wr_q + PtrW'(1)] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_cnt_i);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_q + CntW'(push_cnt_i) - CntW'(pop);
    end
  end

endmodule
`default_nettype wire

@@ hdl/tlvmp_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlvmp_checker
// Port-level checks on the result channel of the message parser.
// ----------------------------------------------------------------------------
module tlvmp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  kind,
  input wire logic [3:0]  field_id,
  input wire logic [63:0] int_value,
  input wire logic [23:0] field_length,
  input wire logic [7:0]  payload_byte,
  input wire logic        last_of_field,
  input wire logic [1:0]  status,
  input wire logic [15:0] set_mask,
  input wire logic        last_result
);

  // A stalled result keeps its contents until its transfer.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(field_id) &&
      $stable(int_value) && $stable(set_mask) && $stable(last_result))
    else $error("result changed while stalled");

  // The status always closes the results of its byte.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && kind == tlvmp_pkg::KIND_STATUS |-> last_result &&
      field_id == 4'd0 && int_value == 64'd0)
    else $error("status result malformed");

  // Field results never carry status or mask bits.
  a_field_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && kind != tlvmp_pkg::KIND_STATUS |-> status == 2'd0 && set_mask == 16'd0)
    else $error("field result carries status");

  // Only payload bytes carry a byte and an end-of-field flag.
  a_payload_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && kind != tlvmp_pkg::KIND_PAYLOAD |-> !last_of_field &&
      payload_byte == 8'd0 &&
      (kind == tlvmp_pkg::KIND_BUF_START || field_length == 24'd0))
    else $error("payload fields on a non-payload result");

endmodule

bind tlv_message_parser_core tlvmp_checker u_tlvmp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .kind          (out_o.kind),
  .field_id      (out_o.field_id),
  .int_value     (out_o.int_value),
  .field_length  (out_o.field_length),
  .payload_byte  (out_o.payload_byte),
  .last_of_field (out_o.last_of_field),
  .status        (out_o.status),
  .set_mask      (out_o.set_mask),
  .last_result   (out_o.last_result)
);
`default_nettype wire
